// ===== rtl/core/max_pairwise_gcd_top_macros.svh =====
// Assertion macros shared by the RTL of the maximum pairwise GCD block.
`ifndef MAX_PAIRWISE_GCD_TOP_MACROS_SVH
`define MAX_PAIRWISE_GCD_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MGCD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define MGCD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mgcd_pkg.sv =====
package mgcd_pkg;

  // Fixed field widths of the streams.
  localparam int VALUE_W = 16;
  localparam int GCD_W   = 16;

  // Default upper bound on accepted values.
  localparam int VALUE_MAX_DEF = 65535;

  // Completion report from the divisor search to the controller.
  typedef struct packed {
    logic             done;
    logic [GCD_W-1:0] gcd;
  } srch_status_t;

endpackage

// ===== rtl/core/mgcd_map.sv =====
module mgcd_map
  import mgcd_pkg::*;
#(
  parameter int VALUE_MAX = VALUE_MAX_DEF,
  localparam int AW = $clog2(VALUE_MAX + 1)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data
);

  // One presence bit for every value from zero to the upper bound.
  logic mem [0:VALUE_MAX];

  // Single write port and a registered read port; a read of the entry being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/mgcd_search.sv =====
module mgcd_search
  import mgcd_pkg::*;
#(
  parameter int VALUE_MAX = VALUE_MAX_DEF,
  localparam int AW = $clog2(VALUE_MAX + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] dup,
  input  logic               rd_data,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  output srch_status_t       status
);

  localparam logic [AW-1:0] TOP_ADDR = AW'(VALUE_MAX);
  localparam logic [AW:0]   TOP_SUM  = (AW + 1)'(VALUE_MAX);

  logic               busy_r;
  logic               issue_r;
  logic [AW-1:0]      d_r;
  logic [AW-1:0]      m_r;
  logic [VALUE_W-1:0] dup_r;
  logic               rsp_valid_r;
  logic               rsp_first_r;
  logic [AW-1:0]      rsp_d_r;
  logic               cnt_r;
  logic               done_r;
  logic [GCD_W-1:0]   gcd_r;

  logic [AW:0]        m_sum;
  logic [AW-1:0]      d_dec;
  logic               found;

  // Issue side: walk the multiples of the current divisor, one read a cycle.
  always_comb begin
    rd_en   = issue_r;
    rd_addr = m_r;
    m_sum   = {1'b0, m_r} + {1'b0, d_r};
    d_dec   = d_r - 1'b1;
    // A second present multiple of the divisor in flight ends the search.
    found   = rsp_valid_r && rd_data && !rsp_first_r && cnt_r;
    status  = '{done: done_r, gcd: gcd_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      issue_r     <= 1'b0;
      rsp_valid_r <= 1'b0;
      cnt_r       <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        d_r         <= TOP_ADDR;
        m_r         <= TOP_ADDR;
        dup_r       <= dup;
        issue_r     <= 32'(VALUE_MAX) > 32'(dup);
        busy_r      <= 1'b1;
        rsp_valid_r <= 1'b0;
        cnt_r       <= 1'b0;
      end else if (busy_r) begin
        // Response side: the read data lines up with the tags stored here.
        rsp_valid_r <= issue_r;
        rsp_first_r <= (m_r == d_r);
        rsp_d_r     <= d_r;
        if (rsp_valid_r) begin
          cnt_r <= rsp_first_r ? rd_data : (cnt_r | rd_data);
        end
        // Step to the next multiple, or down to the next divisor.
        if (issue_r) begin
          if (m_sum > TOP_SUM) begin
            d_r <= d_dec;
            m_r <= d_dec;
            if (32'(d_dec) <= 32'(dup_r)) begin
              issue_r <= 1'b0;
            end
          end else begin
            m_r <= m_sum[AW-1:0];
          end
        end
        // Finish on a hit pair, or once every divisor above the duplicate is spent.
        if (found) begin
          issue_r     <= 1'b0;
          rsp_valid_r <= 1'b0;
          busy_r      <= 1'b0;
          done_r      <= 1'b1;
          gcd_r       <= GCD_W'(rsp_d_r);
        end else if (!issue_r && !rsp_valid_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          gcd_r  <= GCD_W'(dup_r);
        end
      end
    end
  end

endmodule

// ===== rtl/core/max_pairwise_gcd_top.sv =====
// Maximum pairwise GCD of a set of integers. Values arrive on the input
// stream, one per item, with tlast on the final one; zero and values above
// VALUE_MAX are ignored apart from their tlast. Loading takes one item per
// cycle: each value is looked up and marked in a one-bit presence memory of
// VALUE_MAX+1 entries, and a value seen twice raises the largest duplicate.
// After the final item the block walks divisors from VALUE_MAX downward,
// reading the multiples of each from the presence memory at one read per
// cycle, and stops at the first divisor above the largest duplicate with two
// present multiples. That search is bounded by the read port. A single result
// item then carries the answer (at least 1). The presence memory is then
// swept clear, one entry per cycle; the same sweep runs after reset, and no
// input item is taken until it ends.
module max_pairwise_gcd_top
  import mgcd_pkg::*;
#(
  parameter int VALUE_MAX = VALUE_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [15:0] value
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [GCD_W-1:0]   out_tdata   // [15:0] max_gcd
);

`include "max_pairwise_gcd_top_macros.svh"

  localparam int AW = $clog2(VALUE_MAX + 1);
  localparam logic [AW-1:0] TOP_ADDR = AW'(VALUE_MAX);

  typedef enum logic [1:0] {ST_CLEAR, ST_LOAD, ST_SEARCH, ST_EMIT} state_t;

  state_t             state_r;
  logic [AW-1:0]      clr_addr_r;
  logic [VALUE_W-1:0] dup_r;
  logic               s1_valid_r;
  logic               s1_mark_r;
  logic               s1_last_r;
  logic [VALUE_W-1:0] s1_value_r;
  logic [AW-1:0]      s1_addr_r;
  logic               fwd_r;
  logic [GCD_W-1:0]   res_r;
  logic               out_tvalid_r;
  logic [GCD_W-1:0]   out_tdata_r;

  logic               accept;
  logic               v_ok;
  logic [AW-1:0]      in_addr;
  logic               present;
  logic [VALUE_W-1:0] dup_nxt;
  logic               srch_start;
  logic               map_wr_en;
  logic [AW-1:0]      map_wr_addr;
  logic               map_wr_data;
  logic [AW-1:0]      map_rd_addr;
  logic               map_rd_data;
  logic               srch_rd_en;
  logic [AW-1:0]      srch_rd_addr;
  srch_status_t       srch_status;

  // Load stage decode and memory port selection.
  always_comb begin
    in_tready  = (state_r == ST_LOAD) && !(s1_valid_r && s1_last_r);
    accept     = in_tvalid && in_tready;
    v_ok       = (in_tdata != '0) && (32'(in_tdata) <= 32'(VALUE_MAX));
    in_addr    = AW'(in_tdata);
    // A value written by the item just ahead counts as present.
    present    = map_rd_data | fwd_r;
    dup_nxt    = (s1_valid_r && s1_mark_r && present && (s1_value_r > dup_r))
                 ? s1_value_r : dup_r;
    srch_start = (state_r == ST_LOAD) && s1_valid_r && s1_last_r;

    map_rd_addr = srch_rd_en ? srch_rd_addr : in_addr;
    if (state_r == ST_CLEAR) begin
      map_wr_en   = 1'b1;
      map_wr_addr = clr_addr_r;
      map_wr_data = 1'b0;
    end else begin
      map_wr_en   = (state_r == ST_LOAD) && s1_valid_r && s1_mark_r;
      map_wr_addr = s1_addr_r;
      map_wr_data = 1'b1;
    end

    out_tvalid = out_tvalid_r;
    out_tdata  = out_tdata_r;
  end

  mgcd_map #(.VALUE_MAX(VALUE_MAX)) u_map (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data)
  );

  mgcd_search #(.VALUE_MAX(VALUE_MAX)) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (srch_start),
    .dup     (dup_nxt),
    .rd_data (map_rd_data),
    .rd_en   (srch_rd_en),
    .rd_addr (srch_rd_addr),
    .status  (srch_status)
  );

  // Controller: clear sweep, load, search and result hand-off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      dup_r        <= VALUE_W'(1);
      s1_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        s1_value_r <= in_tdata;
        s1_addr_r  <= in_addr;
        s1_mark_r  <= v_ok;
        s1_last_r  <= in_tlast;
        fwd_r      <= s1_valid_r && s1_mark_r && v_ok && (s1_addr_r == in_addr);
      end
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == TOP_ADDR) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          dup_r <= dup_nxt;
          if (srch_start) begin
            state_r <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (srch_status.done) begin
            res_r   <= srch_status.gcd;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= res_r;
            out_tvalid_r <= 1'b1;
            dup_r        <= VALUE_W'(1);
            clr_addr_r   <= '0;
            state_r      <= ST_CLEAR;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
    end
  end

  // A new result only ever comes from the hand-off state.
  `MGCD_ASSERT_IMPL(a_out_from_emit, clk, rst_n, $rose(out_tvalid_r), $past(state_r == ST_EMIT), "result raised outside hand-off")
  // The search reports only while the controller waits for it.
  `MGCD_ASSERT_IMPL(a_done_in_search, clk, rst_n, srch_status.done, state_r == ST_SEARCH, "search done outside search state")
  // The search never returns less than the largest duplicate.
  `MGCD_ASSERT_IMPL(a_gcd_ge_dup, clk, rst_n, srch_status.done, srch_status.gcd >= dup_r, "search result below duplicate")
  // The presence memory is left untouched during the search.
  `MGCD_ASSERT_IMPL(a_no_write_in_search, clk, rst_n, state_r == ST_SEARCH, !map_wr_en, "map written during search")
  // The duplicate register never drops below one.
  `MGCD_ASSERT(a_dup_nonzero, clk, rst_n, dup_r != '0, "largest duplicate is zero")

endmodule

// ===== sim/tb_max_pairwise_gcd_top.sv =====
`timescale 1ns / 1ps

module tb_max_pairwise_gcd_top;
  import mgcd_pkg::*;

  localparam int VALUE_MAX  = VALUE_MAX_DEF;
  localparam int MAP_AW     = $clog2(VALUE_MAX + 1);
  localparam int DIR_ROWS   = 21;
  localparam int RAND_ITEMS = 1400;
  // The slowest set (answer 1) has the longest search, then the sweep follows.
  localparam int IDLE_LIMIT = 4000000;
  // Long enough for the next set to load, search and wait behind the held result.
  localparam int RX_HOLD    = 200000;

  // One row of the directed table; pin_on marks a row whose answer is typed in.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               pin_on;
    logic [GCD_W-1:0]   pin_gcd;
  } stim_row_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata   = '0;   // [15:0] value
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [GCD_W-1:0]   out_tdata;         // [15:0] max_gcd

  // Typed answer travelling alongside the item on offer.
  logic               pin_on     = 1'b0;
  logic [GCD_W-1:0]   pin_gcd    = '0;

  // Predictor state: which values are present, and the largest repeated one.
  bit [VALUE_MAX:0]   seen_map   = '0;
  logic [GCD_W-1:0]   dup_max    = GCD_W'(1);
  logic [GCD_W-1:0]   gcd_expect_q[$];
  logic [GCD_W-1:0]   expected_gcd;

  stim_row_t          dir_rows [0:DIR_ROWS-1];
  int                 mismatch_count = 0;
  int                 random_items   = 0;
  int                 idle_cycles    = 0;
  int                 rx_hold_len    = 0;
  bit                 tx_burst       = 1'b0;
  bit                 rx_burst       = 1'b0;

  max_pairwise_gcd_top #(
    .VALUE_MAX (VALUE_MAX)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [GCD_W-1:0] got,
                                 input logic [GCD_W-1:0] want);
    $display("MISMATCH at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Walk divisors downward and stop at the first one with two present multiples
  // that beats the largest duplicate.
  function automatic logic [GCD_W-1:0] sieve_max_gcd();
    int d;
    int m;
    int hits;
    for (d = VALUE_MAX; d > int'(dup_max); d--) begin
      hits = 0;
      for (m = d; m <= VALUE_MAX; m += d) begin
        if (seen_map[MAP_AW'(m)]) begin
          hits++;
          if (hits >= 2) return GCD_W'(d);
        end
      end
    end
    return dup_max;
  endfunction

  function automatic int tx_gap();
    return tx_burst ? 0 : $urandom_range(0, 11);
  endfunction

  // Offer one item after an optional gap and wait until it is taken.
  task automatic offer_value(input logic [VALUE_W-1:0] value, input logic last,
                             input logic p_on, input logic [GCD_W-1:0] p_gcd,
                             input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    pin_on    <= p_on;
    pin_gcd   <= p_gcd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every outstanding answer has been taken.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (gcd_expect_q.size() != 0) @(posedge clk);
  endtask

  // A random set always holds a planted pair or duplicate with a large gcd,
  // which keeps the divisor walk short; the rest is random filler and zeros.
  task automatic send_random_set();
    logic [VALUE_W-1:0] vals[$];
    logic [VALUE_W-1:0] v;
    int fill;
    int kind;
    int d;
    int i;
    kind = $urandom_range(0, 3);
    fill = $urandom_range(50, 90);
    for (i = 0; i < fill; i++) begin
      v = ($urandom_range(0, 15) == 0) ? '0 : VALUE_W'($urandom_range(1, VALUE_MAX));
      vals.push_back(v);
    end
    case (kind)
      0, 3: begin
        d = $urandom_range(26000, 32767);
        vals.insert($urandom_range(0, vals.size()), VALUE_W'(d));
        vals.insert($urandom_range(0, vals.size()), VALUE_W'(2 * d));
      end
      1: begin
        v = VALUE_W'($urandom_range(40000, VALUE_MAX));
        vals.insert($urandom_range(0, vals.size()), v);
        vals.insert($urandom_range(0, vals.size()), v);
      end
      default: begin
        d = $urandom_range(26000, 32767);
        vals.insert($urandom_range(0, vals.size()), VALUE_W'(d));
        vals.insert($urandom_range(0, vals.size()), VALUE_W'(2 * d));
        v = VALUE_W'($urandom_range(20000, 40000));
        vals.insert($urandom_range(0, vals.size()), v);
        vals.insert($urandom_range(0, vals.size()), v);
      end
    endcase
    // Broken sets carry extra zeros and end on a zero item.
    if (kind == 3) begin
      for (i = 0; i < 4; i++) vals.insert($urandom_range(0, vals.size()), '0);
      vals.push_back('0);
    end
    for (i = 0; i < vals.size(); i++) begin
      offer_value(vals[i], (i == vals.size() - 1), 1'b0, '0, tx_gap());
      if (vals[i] != '0) random_items++;
    end
  endtask

  // Input monitor: update the predictor for every accepted item.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tdata != '0 && 32'(in_tdata) <= VALUE_MAX) begin
        if (seen_map[in_tdata]) begin
          if (in_tdata > dup_max) dup_max = in_tdata;
        end else begin
          seen_map[in_tdata] = 1'b1;
        end
      end
      if (in_tlast) begin
        expected_gcd = sieve_max_gcd();
        gcd_expect_q.push_back(pin_on ? pin_gcd : expected_gcd);
        seen_map = '0;
        dup_max  = GCD_W'(1);
      end
    end
  end

  // Output monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (gcd_expect_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_tdata, '0);
      end else begin
        if (out_tdata !== gcd_expect_q[0]) begin
          report_mismatch("max_gcd", out_tdata, gcd_expect_q[0]);
        end
        void'(gcd_expect_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted item on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("max_pairwise_gcd_top verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: a gap or a long hold counts from the moment a result is offered.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        gap = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 11);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        @(posedge clk);
        while (!out_tvalid) @(posedge clk);
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  // Sender: directed table first, then random sets.
  initial begin
    int i;
    int set_count;
    set_count = 0;
    dir_rows = '{
      // A zero is ignored; the lone remaining value gives 1.
      {16'd0,     1'b0, 1'b0, 16'd0},
      {16'd65535, 1'b1, 1'b1, 16'd1},
      // Duplicate of the largest value.
      {16'd65535, 1'b0, 1'b0, 16'd0},
      {16'd65535, 1'b1, 1'b1, 16'd65535},
      // Largest possible pair gcd.
      {16'd32767, 1'b0, 1'b0, 16'd0},
      {16'd65534, 1'b1, 1'b1, 16'd32767},
      // The last flag rides on a zero item.
      {16'd60000, 1'b0, 1'b0, 16'd0},
      {16'd60000, 1'b0, 1'b0, 16'd0},
      {16'd0,     1'b1, 1'b1, 16'd60000},
      // Smallest value alongside a large pair.
      {16'd1,     1'b0, 1'b0, 16'd0},
      {16'd30000, 1'b0, 1'b0, 16'd0},
      {16'd60000, 1'b1, 1'b1, 16'd30000},
      // Alternating bit patterns.
      {16'h5555,  1'b0, 1'b0, 16'd0},
      {16'hAAAA,  1'b1, 1'b0, 16'd0},
      // Pair gcd beats a smaller duplicate.
      {16'd21845, 1'b0, 1'b0, 16'd0},
      {16'd43690, 1'b0, 1'b0, 16'd0},
      {16'd65535, 1'b0, 1'b0, 16'd0},
      {16'd10000, 1'b0, 1'b0, 16'd0},
      {16'd10000, 1'b1, 1'b0, 16'd0},
      // A power of two as the answer.
      {16'd8192,  1'b0, 1'b0, 16'd0},
      {16'd24576, 1'b1, 1'b1, 16'd8192}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < DIR_ROWS; i++) begin
      offer_value(dir_rows[i].value, dir_rows[i].last, dir_rows[i].pin_on,
                  dir_rows[i].pin_gcd, tx_gap());
    end
    while (random_items < RAND_ITEMS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      // Hold a result back while the following sets are still on offer.
      if (set_count == 1) rx_hold_len = RX_HOLD;
      // Now and then let every answer come home before the next set.
      if (set_count % 6 == 5) drain_results();
      send_random_set();
      set_count++;
    end
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("max_pairwise_gcd_top verification clean");
    end else begin
      $display("max_pairwise_gcd_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mgcd_pkg.sv
rtl/core/mgcd_map.sv
rtl/core/mgcd_search.sv
rtl/core/max_pairwise_gcd_top.sv
sim/tb_max_pairwise_gcd_top.sv
